// File: rtl/slcfr_pkg.sv
// shared types, codes and the crc16 step for the framed serial receiver
package slcfr_pkg;

    localparam int CNT_W   = 9;
    localparam int TICK_W  = 10;
    localparam int CRC_W   = 16;

    localparam logic [7:0] HDR0 = 8'hA5;
    localparam logic [7:0] HDR1 = 8'hB6;
    localparam logic [9:0] MIN_FRAME = 10'd13;
    localparam logic [9:0] CRC_START_CNT = 10'd5;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [TICK_W-1:0] TICK_MAX = 10'h3FF;

    localparam logic [8:0] LIMIT_RESET = 9'd256;
    localparam logic [TICK_W-1:0] SYNC_RESET = 10'd500;
    localparam logic [TICK_W-1:0] GAP_RESET = 10'd200;

    // action codes
    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // register indexes
    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_SYNC  = 2'd1;
    localparam logic [1:0] REG_GAP   = 2'd2;

    // result kinds and status codes
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_MORE = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_RECV
    } phase_t;

    // crc16 modbus, one byte folded lsb first
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

// File: rtl/sync_length_crc_frame_receiver.sv
// framed serial receiver: header hunt, frame buffer, length/tail end and crc16 check
//
// input channel (in_valid/in_stall) carries one word per item: action selects a
// received byte, a 1 ms tick or a frame buffer read. one word may be accepted
// every cycle while in_stall is low; all state updates for a word complete in
// the cycle it is taken. results (status reports and buffer read data) appear
// on the output channel (out_valid/out_stall) once the word that caused them
// has passed the read stage (the registered frame buffer read) and the output
// register. words that cause no result (most bytes and ticks) produce nothing.
// the frame buffer is a single memory, written by received bytes and read by
// read words; one access per word, so the two never meet in one cycle.
// cfg writes (cfg_valid/cfg_ready, always ready) set buffer limit, sync window
// and byte gap; the user makes them only while no word is in flight (not enforced).
// reset clears the receive state and restores register defaults; buffer
// contents are left as they are and read undefined until written.
// a stall on the output holds the result; the input stalls only when both the
// read stage and the output register are full, so no word is lost.
module sync_length_crc_frame_receiver
    import slcfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] rx_byte,
    input  logic [7:0] read_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       result_kind,
    output logic [1:0] frame_status,
    output logic [8:0] frame_length,
    output logic [7:0] read_data
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int DW  = $clog2(BUFFER_DEPTH + 1);
    localparam int LW  = (DW > 10) ? DW : 10;
    localparam int CW  = (AW > CNT_W) ? AW : CNT_W;
    localparam int RAW = (AW > 8) ? AW : 8;

    // configuration
    logic [8:0]        limit_reg;
    logic [TICK_W-1:0] sync_reg;
    logic [TICK_W-1:0] gap_reg;

    // receive state
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [3:0][7:0]   hist_reg, hist_next;

    logic [7:0] mem [BUFFER_DEPTH];

    // read stage and output register
    logic       p1_valid_reg;
    logic       p1_kind_reg;
    logic [1:0] p1_status_reg;
    logic [8:0] p1_length_reg;
    logic       p1_zero_reg;
    logic [7:0] rdata_reg;
    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [1:0] out_status_reg;
    logic [8:0] out_length_reg;
    logic [7:0] out_data_reg;

    logic out_free, p1_adv, p1_free, accept;
    logic [LW-1:0] depth_w, lim_w;
    logic [8:0]    lim;
    logic [9:0]    cnt_inc;
    logic [TICK_W-1:0] tc_inc;
    logic is_byte, is_tick, rd_hit;
    logic hdr0_hit, hdr1_hit, sync_lost, recv_byte, overflow, store_byte, tail_seen;
    logic gap_out, sync_out, report;
    logic [CRC_W-1:0] crc_upd, crc_new;
    logic       res_valid;
    logic [1:0] res_status;
    logic [8:0] res_length;
    logic       wr_en;
    logic [CW-1:0]  wr_addr_w;
    logic [RAW-1:0] rd_addr_w;
    logic           rd_beyond;

    assign cfg_ready = 1'b1;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign p1_adv   = p1_valid_reg && out_free;
    assign p1_free  = !p1_valid_reg || p1_adv;
    assign in_stall = !p1_free;
    assign accept   = in_valid && p1_free;

    // effective limit, clamped to the memory depth
    assign depth_w = LW'(BUFFER_DEPTH);
    assign lim_w   = (LW'(limit_reg) < depth_w) ? LW'(limit_reg) : depth_w;
    assign lim     = lim_w[8:0];

    assign cnt_inc = {1'b0, count_reg} + 10'd1;
    assign tc_inc  = (tick_reg < TICK_MAX) ? tick_reg + 1'b1 : tick_reg;

    assign is_byte = accept && (action == ACT_BYTE);
    assign is_tick = accept && (action == ACT_TICK);
    assign rd_hit  = accept && (action == ACT_READ);

    assign hdr0_hit  = is_byte && (phase_reg == PH_HUNT) && (rx_byte == HDR0);
    assign hdr1_hit  = is_byte && (phase_reg == PH_SYNC) && (rx_byte == HDR1);
    assign sync_lost = is_byte && (phase_reg == PH_SYNC) && (rx_byte != HDR1)
                       && (rx_byte != HDR0);
    assign recv_byte = is_byte && (phase_reg == PH_RECV);
    assign overflow  = recv_byte && ((lim == 9'd0) || (cnt_inc >= {1'b0, lim}));
    assign store_byte = recv_byte && !overflow;
    // b6 a5 ends the frame, which also covers the tail at 13 plus the length byte
    assign tail_seen = store_byte && (hist_reg[0] == HDR1) && (rx_byte == HDR0);
    assign gap_out   = is_tick && (phase_reg == PH_RECV) && (tc_inc >= gap_reg);
    assign sync_out  = is_tick && (phase_reg != PH_RECV) && (tc_inc >= sync_reg);
    assign report    = overflow || tail_seen || gap_out || sync_out;

    // crc runs four bytes behind the newest one
    assign crc_upd = crc_fold(crc_reg, hist_reg[3]);
    assign crc_new = (cnt_inc >= CRC_START_CNT) ? crc_upd : crc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (report)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (hdr0_hit)
                        phase_next = PH_SYNC;
                end
                PH_SYNC:
                begin
                    if (hdr1_hit)
                        phase_next = PH_RECV;
                    else if (sync_lost)
                        phase_next = PH_HUNT;
                end
                PH_RECV:
                begin
                    phase_next = PH_RECV;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        tick_next  = tick_reg;
        crc_next   = crc_reg;
        hist_next  = hist_reg;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_length = 9'd0;

        if (overflow || gap_out)
        begin
            res_valid  = 1'b1;
            res_status = ST_ERR;
        end
        else if (sync_out)
        begin
            res_valid  = 1'b1;
            res_status = ST_MORE;
        end
        else if (tail_seen)
        begin
            res_valid = 1'b1;
            if (cnt_inc < MIN_FRAME || {hist_reg[2], hist_reg[1]} != crc_new)
                res_status = ST_ERR;
            else
                res_length = cnt_inc[8:0];
        end

        if (report)
        begin
            count_next = '0;
            tick_next  = '0;
            crc_next   = CRC_INIT;
            hist_next  = '0;
        end
        else if (is_tick)
        begin
            tick_next = tc_inc;
        end
        else if (hdr0_hit)
        begin
            count_next = CNT_W'(1);
        end
        else if (hdr1_hit)
        begin
            count_next = CNT_W'(2);
            tick_next  = '0;
            crc_next   = CRC_INIT;
            hist_next  = {8'h00, 8'h00, HDR0, HDR1};
        end
        else if (sync_lost)
        begin
            count_next = '0;
        end
        else if (store_byte)
        begin
            count_next = cnt_inc[CNT_W-1:0];
            tick_next  = '0;
            crc_next   = crc_new;
            hist_next  = {hist_reg[2:0], rx_byte};
        end
    end

    // count sits at the next free position in every phase
    assign wr_en     = hdr0_hit || hdr1_hit || store_byte;
    assign wr_addr_w = CW'(count_reg);
    assign rd_addr_w = RAW'(read_index);
    assign rd_beyond = (LW'(read_index) >= depth_w);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr_w[AW-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (rd_hit)
            rdata_reg <= mem[rd_addr_w[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            sync_reg  <= SYNC_RESET;
            gap_reg   <= GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIMIT: limit_reg <= cfg_data[8:0];
                REG_SYNC:  sync_reg  <= cfg_data;
                REG_GAP:   gap_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            tick_reg  <= '0;
            crc_reg   <= CRC_INIT;
            hist_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
            crc_reg   <= crc_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_free)
                p1_valid_reg <= res_valid || rd_hit;
            if (out_free)
                out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_free)
        begin
            p1_kind_reg   <= rd_hit ? KIND_READ : KIND_STATUS;
            p1_status_reg <= res_status;
            p1_length_reg <= res_length;
            p1_zero_reg   <= rd_beyond;
        end
        if (p1_adv)
        begin
            out_kind_reg   <= p1_kind_reg;
            out_status_reg <= p1_status_reg;
            out_length_reg <= p1_length_reg;
            out_data_reg   <= (p1_kind_reg == KIND_READ && !p1_zero_reg) ? rdata_reg : 8'h00;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign frame_status = out_status_reg;
    assign frame_length = out_length_reg;
    assign read_data    = out_data_reg;

endmodule

// File: rtl/slcfr_chk.sv
// port checker for the framed serial receiver, bound to the top level
module slcfr_chk
    import slcfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       result_kind,
    input logic [1:0] frame_status,
    input logic [8:0] frame_length,
    input logic [7:0] read_data
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_length)
        && $stable(read_data) && $stable(frame_status))
        else $error("stalled output word changed");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_READ |-> frame_status == ST_OK
        && frame_length == 9'd0)
        else $error("read word carries status fields");

    a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS |-> read_data == 8'h00)
        else $error("status word carries read data");

    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS && frame_status != ST_OK
        |-> frame_length == 9'd0)
        else $error("failed frame reports a length");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS && frame_status == ST_OK
        |-> frame_length >= 9'd13)
        else $error("good frame shorter than minimum");

endmodule

bind sync_length_crc_frame_receiver slcfr_chk u_slcfr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .frame_status (frame_status),
    .frame_length (frame_length),
    .read_data    (read_data)
);

// File: test/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the framed serial receiver: header hunt, frame end and crc16
module tb;
    import slcfr_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;   // spare action code, the block ignores it
    localparam logic [8:0] LEN_POS = 9'd7;
    localparam int FR_GOOD = 0;
    localparam int FR_BAD_CRC = 1;
    localparam int FR_CUT = 2;
    localparam int FR_BAD_LEN = 3;
    localparam int FR_EXTREMES = 4;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [8:0] length;
        logic [7:0] data;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       result_kind;
    logic [1:0] frame_status;
    logic [8:0] frame_length;
    logic [7:0] read_data;

    // receiver state as the testbench follows it
    phase_t      rx_phase;
    logic [8:0]  rx_count;
    logic [9:0]  rx_ticks;
    logic [7:0]  rx_prev;
    logic [15:0] rx_crc;
    logic [7:0]  rx_store [256];
    bit          store_written [256];
    logic [8:0]  lim_reg;
    logic [9:0]  sync_reg;
    logic [9:0]  gap_reg;

    reply_t due_replies[$];
    reply_t want_reply;
    int     mismatches = 0;
    int     words_sent = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;

    sync_length_crc_frame_receiver dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic restart_hunt();
        rx_phase = PH_HUNT;
        rx_count = '0;
        rx_ticks = '0;
        rx_prev = '0;
        rx_crc = CRC_INIT;
    endtask

    task automatic finish_frame(input logic [1:0] status, input logic [8:0] len);
        due_replies.push_back('{KIND_STATUS, status, len, 8'h00});
        restart_hunt();
    endtask

    // expected response of the receiver to one accepted word
    task automatic receiver_step(input logic [1:0] act, input logic [7:0] b,
                                 input logic [7:0] idx);
        logic [8:0] lim;
        logic       tail;
        lim = (lim_reg > 9'd256) ? 9'd256 : lim_reg;
        if (act == ACT_READ)
        begin
            due_replies.push_back('{KIND_READ, ST_OK, 9'd0, rx_store[idx]});
        end
        else if (act == ACT_TICK)
        begin
            if (rx_ticks != TICK_MAX)
                rx_ticks++;
            if (rx_phase == PH_RECV)
            begin
                if (rx_ticks >= gap_reg)
                    finish_frame(ST_ERR, '0);
            end
            else if (rx_ticks >= sync_reg)
            begin
                finish_frame(ST_MORE, '0);
            end
        end
        else if (act == ACT_BYTE)
        begin
            case (rx_phase)
                PH_HUNT:
                begin
                    if (b == HDR0)
                    begin
                        rx_store[0] = HDR0;
                        store_written[0] = 1'b1;
                        rx_count = 9'd1;
                        rx_phase = PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    if (b == HDR1)
                    begin
                        rx_store[1] = HDR1;
                        store_written[1] = 1'b1;
                        rx_count = 9'd2;
                        rx_phase = PH_RECV;
                        rx_ticks = '0;
                        rx_crc = CRC_INIT;
                        rx_prev = HDR1;
                    end
                    else if (b != HDR0)
                    begin
                        rx_phase = PH_HUNT;
                        rx_count = '0;
                    end
                end
                default:
                begin
                    rx_ticks = '0;
                    if (rx_count + 9'd1 >= lim)
                    begin
                        finish_frame(ST_ERR, '0);
                    end
                    else
                    begin
                        rx_store[rx_count[7:0]] = b;
                        store_written[rx_count[7:0]] = 1'b1;
                        rx_count++;
                        // crc trails the write pointer by four bytes
                        if (rx_count >= CRC_START_CNT)
                            rx_crc = crc16_step(rx_crc, rx_store[8'(rx_count - 9'd5)]);
                        // a tail at the length position is the same b6 a5 pair, so one test
                        tail = (rx_prev == HDR1) && (b == HDR0);
                        rx_prev = b;
                        if (tail)
                        begin
                            if (rx_count < MIN_FRAME)
                                finish_frame(ST_ERR, '0);
                            else if ({rx_store[8'(rx_count - 9'd4)],
                                      rx_store[8'(rx_count - 9'd3)]} != rx_crc)
                                finish_frame(ST_ERR, '0);
                            else
                                finish_frame(ST_OK, rx_count);
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic send_word(input logic [1:0] act, input logic [7:0] b,
                             input logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            action <= 2'($urandom);
            rx_byte <= 8'($urandom);
            read_index <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        rx_byte <= b;
        read_index <= idx;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        receiver_step(act, b, idx);
        words_sent++;
        @(negedge clk);
    endtask

    // read some entry that a frame byte has already filled
    task automatic read_back();
        logic [7:0] idx;
        if (store_written[0])
        begin
            idx = 8'($urandom);
            while (!store_written[idx])
                idx = idx >> 1;
            send_word(ACT_READ, 8'($urandom), idx);
        end
    endtask

    task automatic send_frame(input int len, input int flavor);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        int          i;
        int          n;
        fr = {HDR0, HDR1};
        for (i = 2; i < 9 + len; i++)
        begin
            if (i == int'(LEN_POS))
                fr.push_back(flavor == FR_BAD_LEN ? 8'($urandom) : 8'(len));
            else if (flavor == FR_EXTREMES)
                fr.push_back(i[0] ? 8'hFF : 8'h00);
            else
                fr.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        for (i = 0; i < fr.size(); i++)
            crc = crc16_step(crc, fr[i]);
        if (flavor == FR_BAD_CRC)
            crc = crc ^ (16'd1 << $urandom_range(15));
        fr.push_back(crc[15:8]);
        fr.push_back(crc[7:0]);
        fr.push_back(HDR1);
        fr.push_back(HDR0);
        n = (flavor == FR_CUT) ? $urandom_range(fr.size() - 1, 3) : fr.size();
        for (i = 0; i < n; i++)
        begin
            if (i >= 2 && flavor != FR_EXTREMES)
            begin
                if ($urandom_range(99) < 4)
                    send_word(ACT_TICK, 8'($urandom), 8'($urandom));
                else if ($urandom_range(99) < 4)
                    read_back();
            end
            send_word(ACT_BYTE, fr[i], 8'($urandom));
        end
        if (flavor == FR_CUT)
        begin
            if (gap_reg <= 10'd40)
            begin
                repeat (gap_reg)
                    send_word(ACT_TICK, 8'($urandom), 8'($urandom));
            end
            else
            begin
                // too slow to time out, close it with a bare tail
                send_word(ACT_BYTE, HDR1, 8'($urandom));
                send_word(ACT_BYTE, HDR0, 8'($urandom));
            end
        end
    endtask

    function automatic int frame_len();
        return ($urandom_range(99) < 95) ? $urandom_range(16) : $urandom_range(240);
    endfunction

    task automatic run_traffic(input int count);
        int stop_at;
        int pick;
        int k;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_frame(frame_len(), FR_GOOD);
            else if (pick < 52)
                send_frame(frame_len(), FR_BAD_CRC);
            else if (pick < 60)
                send_frame(frame_len(), FR_CUT);
            else if (pick < 65)
                send_frame(frame_len(), FR_BAD_LEN);
            else if (pick < 75)
            begin
                repeat ($urandom_range(6, 1))
                begin
                    k = $urandom_range(3);
                    send_word(ACT_BYTE, (k == 0) ? HDR0 : ((k == 1) ? HDR1 : 8'($urandom)),
                              8'($urandom));
                end
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(3, 1))
                    read_back();
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(4, 1))
                    send_word(ACT_TICK, 8'($urandom), 8'($urandom));
            end
            else
            begin
                send_word(ACT_NONE, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_LIMIT: lim_reg = value[8:0];
            REG_SYNC:  sync_reg = value;
            default:   gap_reg = value;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input logic [8:0] lim, input logic [9:0] sync_ticks,
                             input logic [9:0] gap_ticks);
        wait_idle();
        write_reg(REG_LIMIT, {1'b0, lim});
        write_reg(REG_SYNC, sync_ticks);
        write_reg(REG_GAP, gap_ticks);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        $display("%t ERROR %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (due_replies.size() == 0)
            begin
                report_mismatch("reply with nothing due", {8'h00, result_kind}, 9'h0);
            end
            else
            begin
                want_reply = due_replies.pop_front();
                if (result_kind !== want_reply.kind)
                    report_mismatch("result_kind", {8'h00, result_kind}, {8'h00, want_reply.kind});
                if (frame_status !== want_reply.status)
                    report_mismatch("frame_status", {7'h00, frame_status},
                                    {7'h00, want_reply.status});
                if (frame_length !== want_reply.length)
                    report_mismatch("frame_length", frame_length, want_reply.length);
                if (read_data !== want_reply.data)
                    report_mismatch("read_data", {1'b0, read_data}, {1'b0, want_reply.data});
            end
        end
    end

    task automatic test_basic_frames();
        send_idle_pct = 0;
        stall_pct = 0;
        send_frame(0, FR_EXTREMES);
        send_word(ACT_READ, 8'h00, 8'd0);
        send_word(ACT_READ, 8'hFF, 8'd12);
        // tail right after one data byte is a short frame
        send_word(ACT_BYTE, HDR0, 8'hFF);
        send_word(ACT_BYTE, HDR1, 8'h00);
        send_word(ACT_BYTE, 8'h11, 8'h00);
        send_word(ACT_BYTE, HDR1, 8'h00);
        send_word(ACT_BYTE, HDR0, 8'h00);
        send_word(ACT_TICK, 8'hFF, 8'hFF);
        send_word(ACT_NONE, 8'hFF, 8'hFF);
        run_traffic(40);
    endtask

    task automatic test_header_timeout();
        send_idle_pct = 56;
        stall_pct = 0;
        configure(9'd256, 10'd1, 10'd1023);
        send_word(ACT_TICK, 8'h00, 8'h00);
        send_word(ACT_TICK, 8'h00, 8'h00);
        send_word(ACT_BYTE, HDR0, 8'h00);
        send_word(ACT_TICK, 8'h00, 8'h00);
        configure(9'd256, 10'd9, 10'd1023);
        run_traffic(40);
    endtask

    task automatic test_byte_gap();
        send_idle_pct = 0;
        stall_pct = 56;
        configure(9'd256, 10'd1023, 10'd1);
        send_frame(4, FR_CUT);
        configure(9'd256, 10'd1023, 10'd5);
        run_traffic(40);
    endtask

    task automatic test_buffer_limits();
        send_idle_pct = 30;
        stall_pct = 30;
        configure(9'd13, 10'd1023, 10'd200);
        send_frame(0, FR_GOOD);
        configure(9'd0, 10'd1023, 10'd200);
        send_frame(2, FR_GOOD);
        configure(9'd3, 10'd1023, 10'd200);
        send_frame(2, FR_GOOD);
        configure(9'd511, 10'd1023, 10'd1023);
        send_frame(240, FR_GOOD);
        // length field past the payload limit, runs into the buffer end
        send_frame(250, FR_GOOD);
        configure(9'd14, 10'd30, 10'd20);
        run_traffic(20);
    endtask

    task automatic test_random_traffic();
        for (int r = 0; r < 3; r++)
        begin
            configure(($urandom_range(3) == 0) ? 9'd256 : 9'($urandom_range(80, 13)),
                      $urandom_range(1) ? 10'($urandom_range(40, 1)) : 10'($urandom_range(1023, 1)),
                      $urandom_range(1) ? 10'($urandom_range(40, 1)) : 10'($urandom_range(1023, 1)));
            send_idle_pct = (r == 1) ? 56 : ((r == 2) ? 30 : 0);
            stall_pct = (r == 2) ? 30 : 0;
            run_traffic(40);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_BYTE;
        rx_byte = 8'h00;
        read_index = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_LIMIT;
        cfg_data = '0;
        lim_reg = LIMIT_RESET;
        sync_reg = SYNC_RESET;
        gap_reg = GAP_RESET;
        restart_hunt();
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_frames();
        test_header_timeout();
        test_byte_gap();
        test_buffer_limits();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("sync_length_crc_frame_receiver: match");
        else
            $display("sync_length_crc_frame_receiver: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("sync_length_crc_frame_receiver: mismatch");
        $finish;
    end

endmodule
